// ===== rtl/rhh_pkg.sv =====
// Shared codes and controller/datapath interface types for the Robin Hood hash table.
`default_nettype none
package rhh_pkg;

    localparam logic [2:0] CMD_INSERT   = 3'd0;
    localparam logic [2:0] CMD_LOOKUP   = 3'd1;
    localparam logic [2:0] CMD_REM_KEY  = 3'd2;
    localparam logic [2:0] CMD_REM_SLOT = 3'd3;
    localparam logic [2:0] CMD_CLEAR    = 3'd4;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_DUP   = 3'd1;
    localparam logic [2:0] ST_MISS  = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    localparam int HASH_BITS  = 31;
    localparam int LIMIT_BITS = 11;

    localparam logic [3:0] OP_NONE       = 4'd0;
    localparam logic [3:0] OP_LOAD       = 4'd1;
    localparam logic [3:0] OP_FIND_RD    = 4'd2;
    localparam logic [3:0] OP_FIND_EV    = 4'd3;
    localparam logic [3:0] OP_PLACE_INIT = 4'd4;
    localparam logic [3:0] OP_PLACE_RD   = 4'd5;
    localparam logic [3:0] OP_PLACE_EV   = 4'd6;
    localparam logic [3:0] OP_SI_RD      = 4'd7;
    localparam logic [3:0] OP_SI_EV      = 4'd8;
    localparam logic [3:0] OP_REM_INIT   = 4'd9;
    localparam logic [3:0] OP_REM_RD     = 4'd10;
    localparam logic [3:0] OP_REM_SHIFT  = 4'd11;
    localparam logic [3:0] OP_REM_END    = 4'd12;
    localparam logic [3:0] OP_CLR_INIT   = 4'd13;
    localparam logic [3:0] OP_CLR_STEP   = 4'd14;
    localparam logic [3:0] OP_RESP       = 4'd15;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] status;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       si_ok;
        logic       find_hit;
        logic       find_miss;
        logic       full;
        logic       q_occ;
        logic       rem_wrap;
        logic       rem_stop;
        logic       sweep_last;
        logic       out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/rhh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rhh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire                       aclk,
    input  wire                       we,
    input  wire [$clog2(DEPTH)-1:0]   waddr,
    input  wire [WIDTH-1:0]           wdata,
    input  wire                       re,
    input  wire [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/rhh_ctrl.sv =====
// Command sequencer for the Robin Hood hash table.
`default_nettype none
module rhh_ctrl (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire rhh_pkg::dp_stat_t stat,
    output rhh_pkg::dp_cmd_t       ctl
);
    import rhh_pkg::*;

    localparam logic [3:0] S_SWEEP      = 4'd0;
    localparam logic [3:0] S_IDLE       = 4'd1;
    localparam logic [3:0] S_DISP       = 4'd2;
    localparam logic [3:0] S_FIND_RD    = 4'd3;
    localparam logic [3:0] S_FIND_EV    = 4'd4;
    localparam logic [3:0] S_PLACE_INIT = 4'd5;
    localparam logic [3:0] S_PLACE_RD   = 4'd6;
    localparam logic [3:0] S_PLACE_EV   = 4'd7;
    localparam logic [3:0] S_SI_RD      = 4'd8;
    localparam logic [3:0] S_SI_EV      = 4'd9;
    localparam logic [3:0] S_REM_INIT   = 4'd10;
    localparam logic [3:0] S_REM_RD     = 4'd11;
    localparam logic [3:0] S_REM_EV     = 4'd12;
    localparam logic [3:0] S_REM_END    = 4'd13;
    localparam logic [3:0] S_CLR        = 4'd14;
    localparam logic [3:0] S_RESP       = 4'd15;

    logic [3:0] state_reg, state_next;
    logic [2:0] res_reg, res_next;
    logic [3:0] op;

    assign s_ready    = (state_reg == S_IDLE);
    assign ctl.op     = op;
    assign ctl.status = res_reg;

    always_comb begin
        state_next = state_reg;
        res_next   = res_reg;
        op         = OP_NONE;
        case (state_reg)
            S_SWEEP: begin
                op = OP_CLR_STEP;
                if (stat.sweep_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    op         = OP_LOAD;
                    res_next   = ST_OK;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                case (stat.cmd)
                    CMD_INSERT, CMD_LOOKUP, CMD_REM_KEY: state_next = S_FIND_RD;
                    CMD_REM_SLOT: begin
                        if (stat.si_ok) begin
                            state_next = S_SI_RD;
                        end else begin
                            res_next   = ST_EMPTY;
                            state_next = S_RESP;
                        end
                    end
                    CMD_CLEAR: begin
                        op         = OP_CLR_INIT;
                        state_next = S_CLR;
                    end
                    default: state_next = S_RESP;
                endcase
            end
            S_FIND_RD: begin
                op         = OP_FIND_RD;
                state_next = S_FIND_EV;
            end
            S_FIND_EV: begin
                op = OP_FIND_EV;
                if (stat.find_hit) begin
                    case (stat.cmd)
                        CMD_INSERT: begin
                            res_next   = ST_DUP;
                            state_next = S_RESP;
                        end
                        CMD_REM_KEY: state_next = S_REM_INIT;
                        default:     state_next = S_RESP;
                    endcase
                end else if (stat.find_miss) begin
                    if (stat.cmd == CMD_INSERT) begin
                        if (stat.full) begin
                            res_next   = ST_FULL;
                            state_next = S_RESP;
                        end else begin
                            state_next = S_PLACE_INIT;
                        end
                    end else begin
                        res_next   = ST_MISS;
                        state_next = S_RESP;
                    end
                end else begin
                    state_next = S_FIND_RD;
                end
            end
            S_PLACE_INIT: begin
                op         = OP_PLACE_INIT;
                state_next = S_PLACE_RD;
            end
            S_PLACE_RD: begin
                op         = OP_PLACE_RD;
                state_next = S_PLACE_EV;
            end
            S_PLACE_EV: begin
                op         = OP_PLACE_EV;
                state_next = stat.q_occ ? S_PLACE_RD : S_RESP;
            end
            S_SI_RD: begin
                op         = OP_SI_RD;
                state_next = S_SI_EV;
            end
            S_SI_EV: begin
                op = OP_SI_EV;
                if (stat.q_occ) begin
                    state_next = S_REM_INIT;
                end else begin
                    res_next   = ST_EMPTY;
                    state_next = S_RESP;
                end
            end
            S_REM_INIT: begin
                op         = OP_REM_INIT;
                state_next = S_REM_RD;
            end
            S_REM_RD: begin
                op         = OP_REM_RD;
                state_next = stat.rem_wrap ? S_REM_END : S_REM_EV;
            end
            S_REM_EV: begin
                if (stat.rem_stop) begin
                    state_next = S_REM_END;
                end else begin
                    op         = OP_REM_SHIFT;
                    state_next = S_REM_RD;
                end
            end
            S_REM_END: begin
                op         = OP_REM_END;
                state_next = S_RESP;
            end
            S_CLR: begin
                op = OP_CLR_STEP;
                if (stat.sweep_last) state_next = S_RESP;
            end
            S_RESP: begin
                op = OP_RESP;
                if (stat.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_SWEEP;
            res_reg   <= ST_OK;
        end else begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/rhh_dp.sv =====
// Datapath: slot store, probe and shift registers, counters and result register.
`default_nettype none
module rhh_dp #(
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 32
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire rhh_pkg::dp_cmd_t  ctl,
    output rhh_pkg::dp_stat_t      stat,
    input  wire        [2:0]       s_cmd,
    input  wire        [31:0]      s_key,
    input  wire        [30:0]      s_hash,
    input  wire        [9:0]       s_slot_index,
    input  wire                    cfg_wr_en,
    input  wire        [10:0]      cfg_wr_data,
    output logic                   m_valid,
    input  wire                    m_ready,
    output logic       [2:0]       m_status,
    output logic       [9:0]       m_found_slot,
    output logic       [10:0]      m_entry_total
);
    import rhh_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int W  = 1 + HASH_BITS + KEY_BITS;
    localparam int LIMIT_RAW   = CAPACITY * 80 / 100;
    localparam int LIMIT_RESET = (LIMIT_RAW > 2047) ? 2047 : LIMIT_RAW;

    logic [2:0]            cmd_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [HASH_BITS-1:0]  hash_reg;
    logic [9:0]            si_reg;
    logic [IW-1:0]         idx_reg, idx_next;
    logic [IW-1:0]         n_reg, n_next;
    logic [IW:0]           d_reg, d_next;
    logic [IW-1:0]         cur_reg, cur_next;
    logic [IW-1:0]         start_reg, start_next;
    logic [IW-1:0]         slot_reg, slot_next;
    logic [IW-1:0]         rd_addr_reg, rd_addr_next;
    logic                  have_reg, have_next;
    logic [HASH_BITS-1:0]  car_hash_reg, car_hash_next;
    logic [KEY_BITS-1:0]   car_key_reg, car_key_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [LIMIT_BITS-1:0] limit_reg;
    logic                  mv_reg, mv_next;
    logic [2:0]            st_reg, st_next;
    logic [9:0]            fs_reg, fs_next;
    logic [10:0]           tot_reg, tot_next;

    logic                  ram_we, ram_re;
    logic [IW-1:0]         ram_waddr, ram_raddr;
    logic [W-1:0]          ram_wdata, ram_q;
    logic                  q_occ;
    logic [HASH_BITS-1:0]  q_hash;
    logic [KEY_BITS-1:0]   q_key;
    logic [IW-1:0]         pdist;
    logic                  swap;

    rhh_ram #(.WIDTH(W), .DEPTH(1 << IW)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    assign q_occ  = ram_q[W-1];
    assign q_hash = ram_q[W-2 -: HASH_BITS];
    assign q_key  = ram_q[KEY_BITS-1:0];
    assign pdist  = rd_addr_reg - q_hash[IW-1:0];
    assign swap   = q_occ && ({1'b0, pdist} < d_reg);

    assign stat.cmd       = cmd_reg;
    assign stat.si_ok     = 32'(si_reg) < CAPACITY;
    assign stat.find_hit  = q_occ && !(pdist < n_reg) && (q_key == key_reg);
    assign stat.find_miss = !stat.find_hit
                            && (!q_occ || pdist < n_reg || n_reg == IW'(CAPACITY - 1));
    assign stat.full      = (32'(count_reg) >= 32'(limit_reg)) || (32'(count_reg) >= CAPACITY);
    assign stat.q_occ     = q_occ;
    assign stat.rem_wrap  = (cur_reg + IW'(1)) == start_reg;
    assign stat.rem_stop  = !q_occ || pdist == '0;
    assign stat.sweep_last = idx_reg == IW'(CAPACITY - 1);
    assign stat.out_free  = !mv_reg || m_ready;

    assign m_valid       = mv_reg;
    assign m_status      = st_reg;
    assign m_found_slot  = fs_reg;
    assign m_entry_total = tot_reg;

    always_comb begin
        idx_next      = idx_reg;
        n_next        = n_reg;
        d_next        = d_reg;
        cur_next      = cur_reg;
        start_next    = start_reg;
        slot_next     = slot_reg;
        rd_addr_next  = rd_addr_reg;
        have_next     = have_reg;
        car_hash_next = car_hash_reg;
        car_key_next  = car_key_reg;
        count_next    = count_reg;
        mv_next       = mv_reg && !m_ready;
        st_next       = st_reg;
        fs_next       = fs_reg;
        tot_next      = tot_reg;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = '0;
        ram_re        = 1'b0;
        ram_raddr     = idx_reg;
        case (ctl.op)
            OP_LOAD: begin
                idx_next  = s_hash[IW-1:0];
                n_next    = '0;
                slot_next = '0;
            end
            OP_FIND_RD, OP_PLACE_RD: begin
                ram_re       = 1'b1;
                rd_addr_next = idx_reg;
            end
            OP_FIND_EV: begin
                if (stat.find_hit) slot_next = rd_addr_reg;
                idx_next = idx_reg + IW'(1);
                n_next   = n_reg + IW'(1);
            end
            OP_PLACE_INIT: begin
                idx_next      = hash_reg[IW-1:0];
                d_next        = '0;
                have_next     = 1'b0;
                car_hash_next = hash_reg;
                car_key_next  = key_reg;
            end
            OP_PLACE_EV: begin
                idx_next = idx_reg + IW'(1);
                d_next   = d_reg + (IW+1)'(1);
                if (!q_occ || swap) begin
                    ram_we    = 1'b1;
                    ram_waddr = rd_addr_reg;
                    ram_wdata = {1'b1, car_hash_reg, car_key_reg};
                end
                if (!q_occ) begin
                    if (!have_reg) slot_next = rd_addr_reg;
                    count_next = count_reg + CW'(1);
                end else if (swap) begin
                    car_hash_next = q_hash;
                    car_key_next  = q_key;
                    if (!have_reg) slot_next = rd_addr_reg;
                    have_next = 1'b1;
                    d_next    = {1'b0, pdist} + (IW+1)'(1);
                end
            end
            OP_SI_RD: begin
                ram_re       = 1'b1;
                ram_raddr    = IW'(si_reg);
                rd_addr_next = IW'(si_reg);
            end
            OP_SI_EV: begin
                if (q_occ) slot_next = rd_addr_reg;
            end
            OP_REM_INIT: begin
                cur_next   = slot_reg;
                start_next = slot_reg;
            end
            OP_REM_RD: begin
                ram_re       = 1'b1;
                ram_raddr    = cur_reg + IW'(1);
                rd_addr_next = cur_reg + IW'(1);
            end
            OP_REM_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg;
                ram_wdata = {1'b1, q_hash, q_key};
                cur_next  = rd_addr_reg;
            end
            OP_REM_END: begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg;
                if (count_reg != '0) count_next = count_reg - CW'(1);
            end
            OP_CLR_INIT: begin
                idx_next   = '0;
                count_next = '0;
            end
            OP_CLR_STEP: begin
                ram_we   = 1'b1;
                idx_next = idx_reg + IW'(1);
            end
            OP_RESP: begin
                if (stat.out_free) begin
                    mv_next  = 1'b1;
                    st_next  = ctl.status;
                    fs_next  = 10'(slot_reg);
                    tot_next = 11'(count_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            count_reg <= '0;
            limit_reg <= LIMIT_BITS'(LIMIT_RESET);
            mv_reg    <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            count_reg <= count_next;
            mv_reg    <= mv_next;
            if (cfg_wr_en) limit_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.op == OP_LOAD) begin
            cmd_reg  <= s_cmd;
            key_reg  <= KEY_BITS'(s_key);
            hash_reg <= s_hash;
            si_reg   <= s_slot_index;
        end
        n_reg        <= n_next;
        d_reg        <= d_next;
        cur_reg      <= cur_next;
        start_reg    <= start_next;
        slot_reg     <= slot_next;
        rd_addr_reg  <= rd_addr_next;
        have_reg     <= have_next;
        car_hash_reg <= car_hash_next;
        car_key_reg  <= car_key_next;
        st_reg       <= st_next;
        fs_reg       <= fs_next;
        tot_reg      <= tot_next;
    end
endmodule
`default_nettype wire

// ===== rtl/robin_hood_hash_table.sv =====
// Top level of the Robin Hood hash table with backward-shift removal.
//
// Requests enter on the s_ channel (valid/ready) carrying cmd, key, hash and
// slot_index; one result per request leaves on the m_ channel with status,
// found_slot and entry_total. One request is in service at a time.
// Probing visits each slot with a registered read of the slot RAM and then
// an evaluate step. A lookup runs a dispatch step, the probe, and a load of
// the result register. An insert that places its key adds an init step and a
// read and an evaluate per slot walked; a remove adds an init step, a read
// and an evaluate per slot walked in the backward shift, and an end step;
// remove at slot reads and checks its slot instead of probing. A clear sweeps
// every slot empty. s_ready returns in the same cycle as the result is loaded.
// After reset the block sweeps all CAPACITY slots empty, one per cycle, with
// s_ready low; cfg writes are taken throughout. load_limit resets to
// CAPACITY*80/100 (capped at 2047) and is written by cfg_wr_en/cfg_wr_data;
// the user must write it only while idle, as the block does not enforce it.
// A finished result sits in the output register; if the receiver stalls,
// the next request is accepted and worked on, and its result waits until the
// output register is free.
`default_nettype none
module robin_hood_hash_table #(
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [2:0]  s_cmd,
    input  wire  [31:0] s_key,
    input  wire  [30:0] s_hash,
    input  wire  [9:0]  s_slot_index,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [2:0]  m_status,
    output logic [9:0]  m_found_slot,
    output logic [10:0] m_entry_total,
    input  wire         cfg_wr_en,
    input  wire  [10:0] cfg_wr_data
);
    import rhh_pkg::*;

    dp_cmd_t  ctl;
    dp_stat_t stat;

    rhh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctl     (ctl)
    );

    rhh_dp #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl),
        .stat          (stat),
        .s_cmd         (s_cmd),
        .s_key         (s_key),
        .s_hash        (s_hash),
        .s_slot_index  (s_slot_index),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found_slot  (m_found_slot),
        .m_entry_total (m_entry_total)
    );
endmodule
`default_nettype wire

// ===== rtl/rhh_checker.sv =====
// Port-level assertions for the Robin Hood hash table, bound to the top level.
`default_nettype none
module rhh_checker #(
    parameter int CAPACITY = 1024
) (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_valid,
    input wire        s_ready,
    input wire        m_valid,
    input wire        m_ready,
    input wire [2:0]  m_status,
    input wire [9:0]  m_found_slot,
    input wire [10:0] m_entry_total
);
    import rhh_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_entry_total))
        else $error("result changed while stalled");

    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while one is in service");

    a_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_entry_total) <= CAPACITY)
        else $error("entry total past capacity");

    a_refused_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_FULL || m_status == ST_MISS || m_status == ST_EMPTY)
        |-> m_found_slot == '0)
        else $error("refused request reports a slot");

    a_dup_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_DUP |-> m_entry_total != '0)
        else $error("duplicate reported on empty table");
endmodule

bind robin_hood_hash_table rhh_checker #(.CAPACITY(CAPACITY)) u_rhh_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_found_slot  (m_found_slot),
    .m_entry_total (m_entry_total)
);
`default_nettype wire

// ===== tb/tb_robin_hood_hash_table.sv =====
// Testbench for robin_hood_hash_table: random and directed requests checked against a table model.
`default_nettype none
module tb_robin_hood_hash_table;
    timeunit 1ns;
    timeprecision 1ps;
    import rhh_pkg::*;

    localparam int SLOTS = 1024;

    class table_scoreboard;
        bit                occ [SLOTS];
        logic [30:0]       hsh [SLOTS];
        logic [31:0]       kst [SLOTS];
        int unsigned       count;
        int unsigned       limit;
        logic [2:0]        exp_status [$];
        logic [9:0]        exp_slot [$];
        logic [10:0]       exp_total [$];
        int                errors;

        function new();
            count = 0;
            limit = SLOTS * 80 / 100;
            errors = 0;
            foreach (occ[i]) occ[i] = 0;
        endfunction

        function int unsigned probe_dist(int unsigned idx, logic [30:0] h);
            int unsigned home;
            home = h & (SLOTS - 1);
            return idx >= home ? idx - home : SLOTS + idx - home;
        endfunction

        function bit find(logic [31:0] k, logic [30:0] h, output int unsigned slot);
            int unsigned idx;
            int unsigned d;
            idx = h & (SLOTS - 1);
            d = 0;
            slot = 0;
            for (int n = 0; n < SLOTS; n++) begin
                if (!occ[idx] || probe_dist(idx, hsh[idx]) < d) return 0;
                if (kst[idx] == k) begin
                    slot = idx;
                    return 1;
                end
                d++;
                idx = (idx + 1) % SLOTS;
            end
            return 0;
        endfunction

        function int unsigned place(logic [31:0] k, logic [30:0] h);
            int unsigned idx, d, placed, nd;
            logic [30:0] th;
            logic [31:0] tk;
            bit have;
            idx = h & (SLOTS - 1);
            d = 0;
            placed = 0;
            have = 0;
            for (int n = 0; n < SLOTS; n++) begin
                if (!occ[idx]) begin
                    occ[idx] = 1;
                    hsh[idx] = h;
                    kst[idx] = k;
                    return have ? placed : idx;
                end
                nd = probe_dist(idx, hsh[idx]);
                if (nd < d) begin
                    th = hsh[idx];
                    tk = kst[idx];
                    hsh[idx] = h;
                    kst[idx] = k;
                    h = th;
                    k = tk;
                    if (!have) begin
                        placed = idx;
                        have = 1;
                    end
                    d = nd;
                end
                d++;
                idx = (idx + 1) % SLOTS;
            end
            return placed;
        endfunction

        function void shift_out(int unsigned slot);
            int unsigned cur, nx;
            cur = slot;
            for (int n = 0; n < SLOTS; n++) begin
                nx = (cur + 1) % SLOTS;
                if (nx == slot || !occ[nx] || probe_dist(nx, hsh[nx]) == 0) break;
                hsh[cur] = hsh[nx];
                kst[cur] = kst[nx];
                cur = nx;
            end
            occ[cur] = 0;
            if (count > 0) count--;
        endfunction

        function void note_request(logic [2:0] cmd, logic [31:0] k, logic [30:0] h,
                                   logic [9:0] si);
            logic [2:0] st;
            int unsigned slot;
            st = ST_OK;
            slot = 0;
            case (cmd)
                CMD_INSERT: begin
                    if (find(k, h, slot)) begin
                        st = ST_DUP;
                    end else if (count >= limit || count >= SLOTS) begin
                        st = ST_FULL;
                        slot = 0;
                    end else begin
                        slot = place(k, h);
                        count++;
                    end
                end
                CMD_LOOKUP: begin
                    if (!find(k, h, slot)) st = ST_MISS;
                end
                CMD_REM_KEY: begin
                    if (find(k, h, slot)) shift_out(slot);
                    else st = ST_MISS;
                end
                CMD_REM_SLOT: begin
                    if (occ[si]) begin
                        shift_out(si);
                        slot = si;
                    end else begin
                        st = ST_EMPTY;
                    end
                end
                CMD_CLEAR: begin
                    foreach (occ[i]) occ[i] = 0;
                    count = 0;
                end
                default: ;
            endcase
            exp_status.push_back(st);
            exp_slot.push_back(slot[9:0]);
            exp_total.push_back(count[10:0]);
        endfunction

        function void check_result(logic [2:0] st, logic [9:0] slot, logic [10:0] total);
            logic [2:0] es;
            logic [9:0] ef;
            logic [10:0] et;
            if (exp_status.size() == 0) begin
                $error("unexpected result status=%0d", st);
                errors++;
                return;
            end
            es = exp_status.pop_front();
            ef = exp_slot.pop_front();
            et = exp_total.pop_front();
            if (st !== es) begin
                $error("status expected %0d actual %0d", es, st);
                errors++;
            end
            if (slot !== ef) begin
                $error("found_slot expected %0d actual %0d", ef, slot);
                errors++;
            end
            if (total !== et) begin
                $error("entry_total expected %0d actual %0d", et, total);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [2:0]  s_cmd = '0;
    logic [31:0] s_key = '0;
    logic [30:0] s_hash = '0;
    logic [9:0]  s_slot_index = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [2:0]  m_status;
    logic [9:0]  m_found_slot;
    logic [10:0] m_entry_total;
    logic        cfg_wr_en = 0;
    logic [10:0] cfg_wr_data = '0;

    table_scoreboard sb = new();
    bit stall_mode;
    logic [31:0] keys [64];

    robin_hood_hash_table DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_key(s_key),
        .s_hash(s_hash), .s_slot_index(s_slot_index),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_found_slot(m_found_slot), .m_entry_total(m_entry_total),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_status, m_found_slot, m_entry_total);
        if (!stall_mode) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_request(s_cmd, s_key, s_hash, s_slot_index);
    end

    task automatic send(logic [2:0] cmd, logic [31:0] k, logic [30:0] h, logic [9:0] si);
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_key <= k;
        s_hash <= h;
        s_slot_index <= si;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic pause(int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.exp_status.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_limit(int unsigned v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v[10:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.limit = v;
    endtask

    // Random request biased toward a small key pool so hits and clusters occur.
    task automatic random_request(int unsigned spread);
        int unsigned r, p;
        logic [2:0] cmd;
        logic [30:0] h;
        r = $urandom_range(0, 99);
        p = $urandom_range(0, 63);
        if (r < 45) cmd = CMD_INSERT;
        else if (r < 70) cmd = CMD_LOOKUP;
        else if (r < 85) cmd = CMD_REM_KEY;
        else if (r < 97) cmd = CMD_REM_SLOT;
        else if (r < 98) cmd = CMD_CLEAR;
        else cmd = 3'($urandom_range(5, 7));
        h = {21'($urandom()), 10'd0} | 31'($urandom_range(0, spread));
        if ($urandom_range(0, 9) == 0)
            send(cmd, $urandom(), 31'($urandom()), 10'($urandom()));
        else
            send(cmd, keys[p], {h[30:10], keys[p][9:0] & 10'(spread)},
                 10'($urandom_range(0, spread + 2)));
    endtask

    task automatic random_phase(int n, int unsigned spread);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && n > 0) begin
                random_request(spread);
                burst--;
                n--;
            end
            if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 20));
        end
    endtask

    initial begin
        foreach (keys[i]) keys[i] = $urandom();
        keys[0] = 32'h0;
        keys[1] = 32'hFFFF_FFFF;
        stall_mode = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed
        send(CMD_LOOKUP, 32'h0, 31'h0, 10'd0);
        send(CMD_REM_SLOT, 32'h0, 31'h0, 10'd1023);
        send(CMD_INSERT, 32'h0, 31'h0, 10'd0);
        send(CMD_INSERT, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 10'd1023);
        send(CMD_INSERT, 32'h5, 31'h7FFF_FC00, 10'd0);
        send(CMD_INSERT, 32'h0, 31'h0, 10'd0);
        send(CMD_INSERT, 32'h7, 31'h3FF, 10'd0);
        send(CMD_INSERT, 32'h9, 31'h1, 10'd0);
        send(CMD_LOOKUP, 32'h9, 31'h1, 10'd0);
        send(CMD_LOOKUP, 32'h7, 31'h3FF, 10'd0);
        send(CMD_LOOKUP, 32'h8, 31'h3FF, 10'd0);
        send(CMD_REM_KEY, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 10'd0);
        send(CMD_REM_KEY, 32'h1234, 31'h2, 10'd0);
        send(CMD_REM_SLOT, 32'h0, 31'h0, 10'd0);
        send(CMD_LOOKUP, 32'h9, 31'h1, 10'd0);
        send(3'd5, 32'h0, 31'h0, 10'd0);
        send(3'd7, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 10'h3FF);
        send(CMD_CLEAR, 32'h0, 31'h0, 10'd0);
        send(CMD_LOOKUP, 32'h9, 31'h1, 10'd0);
        drain();
        set_limit(0);
        send(CMD_INSERT, 32'h1, 31'h1, 10'd0);
        drain();
        set_limit(3);
        for (int i = 0; i < 5; i++) send(CMD_INSERT, 32'(i + 20), 31'h3FE, 10'd0);
        drain();
        set_limit(1024);
        stall_mode = 1;
        random_phase(150, 15);
        drain();
        set_limit(1);
        random_phase(30, 7);
        drain();
        stall_mode = 0;
        set_limit(40);
        random_phase(150, 63);
        drain();
        stall_mode = 1;
        set_limit(2047);
        random_phase(170, 1023);
        drain();
        if (sb.errors == 0 && sb.exp_status.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #200ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
